@@ src/planar_pose_frame_transform_unit_defines.svh @@
// Assertion macros shared by the pose transform unit
`ifndef PLANAR_POSE_FRAME_TRANSFORM_UNIT_DEFINES_SVH
`define PLANAR_POSE_FRAME_TRANSFORM_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset
`define PPTF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pose transform assertion failed");

// Check a property on every clock edge, reset included
`define PPTF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pose transform reset assertion failed");

`endif

@@ src/pptf_pkg.sv @@
package pptf_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ANGLE_BITS    = 16;

  // Residual angle width and CORDIC datapath width
  localparam int AW = ANGLE_BITS + 2;
  localparam int CW = 34;
  localparam int DW = 33;
  localparam int PW = DW + CW;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [CW-1:0] GAIN_Q30 = CW'(652032874);

  localparam logic signed [AW-1:0] QUARTER = AW'(1) <<< (ANGLE_BITS - 2);
  localparam logic signed [AW-1:0] HALF    = AW'(1) <<< (ANGLE_BITS - 1);

  localparam int ANG_SHL = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int ANG_SHR = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam int ATAN_SH = 32 - ANGLE_BITS;

  typedef enum logic {
    REQ_TO_FIELD = 1'b0,
    REQ_TO_ROBOT = 1'b1
  } req_t;

  // Arctangent of 2^-i in 2^32 units per turn
  localparam logic [31:0] ATAN_TURN32 [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  // Classified item handed from front to back
  typedef struct packed {
    logic                   flip;
    logic signed [AW-1:0]   ang;
    logic signed [DW-1:0]   a;
    logic signed [DW-1:0]   b;
    logic signed [31:0]     off_x;
    logic signed [31:0]     off_y;
    logic [31:0]            z;
    logic [15:0]            roll;
    logic [15:0]            pitch;
    logic [15:0]            heading;
  } item_t;

  typedef struct packed {
    logic [FIFO_CW-1:0] count;
    logic               push;
    logic               pop;
  } fifo_stat_t;

  // Arctangent entry rounded half up to the angle resolution
  function automatic logic signed [AW-1:0] atan_entry(input int i);
    logic [32:0] t;
    t = {1'b0, ATAN_TURN32[i]};
    t = (t + ((33'd1 << ATAN_SH) >> 1)) >> ATAN_SH;
    return AW'(signed'(t));
  endfunction

  // Move a 16-bit binary angle to the CORDIC angle resolution
  function automatic logic signed [AW-1:0] to_angle(input logic signed [15:0] a16);
    logic signed [AW-1:0] w;
    w = AW'(a16);
    return (w <<< ANG_SHL) >>> ANG_SHR;
  endfunction

endpackage

@@ src/pptf_front.sv @@
module pptf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                req_type,
  input  logic [223:0]        in_data,
  output logic                item_valid,
  input  logic                item_ready,
  output pptf_pkg::item_t     item
);

  logic                       vld_r, vld_nxt;
  pptf_pkg::item_t            item_r, item_nxt;
  logic signed [31:0]         px, py, rx, ry;
  logic signed [15:0]         ph, rh, rot16;
  logic signed [pptf_pkg::AW-1:0] ang;

  assign px = in_data[31:0];
  assign py = in_data[63:32];
  assign ph = in_data[143:128];
  assign rx = in_data[175:144];
  assign ry = in_data[207:176];
  assign rh = in_data[223:208];

  assign in_ready = !vld_r || item_ready;

  // Classify request: pick rotation angle, operands and offsets
  always_comb begin
    item_nxt       = item_r;
    item_nxt.z     = in_data[95:64];
    item_nxt.roll  = in_data[111:96];
    item_nxt.pitch = in_data[127:112];
    if (pptf_pkg::req_t'(req_type) == pptf_pkg::REQ_TO_ROBOT) begin
      rot16            = -rh;
      item_nxt.a       = pptf_pkg::DW'(px) - pptf_pkg::DW'(rx);
      item_nxt.b       = pptf_pkg::DW'(py) - pptf_pkg::DW'(ry);
      item_nxt.off_x   = '0;
      item_nxt.off_y   = '0;
      item_nxt.heading = ph - rh;
    end else begin
      rot16            = rh;
      item_nxt.a       = pptf_pkg::DW'(px);
      item_nxt.b       = pptf_pkg::DW'(py);
      item_nxt.off_x   = rx;
      item_nxt.off_y   = ry;
      item_nxt.heading = ph + rh;
    end
    // Fold angles beyond a quarter turn by a half turn
    ang           = pptf_pkg::to_angle(rot16);
    item_nxt.flip = (ang > pptf_pkg::QUARTER) || (ang < -pptf_pkg::QUARTER);
    if (item_nxt.flip) begin
      item_nxt.ang = (ang < 0) ? ang + pptf_pkg::HALF : ang - pptf_pkg::HALF;
    end else begin
      item_nxt.ang = ang;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (in_ready) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture item on accept
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = vld_r;
  assign item       = item_r;

endmodule

@@ src/pptf_fifo.sv @@
module pptf_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_valid,
  output logic                 wr_ready,
  input  pptf_pkg::item_t      wr_item,
  output logic                 rd_valid,
  input  logic                 rd_ready,
  output pptf_pkg::item_t      rd_item,
  output pptf_pkg::fifo_stat_t stat
);

  pptf_pkg::item_t                  mem [pptf_pkg::FIFO_DEPTH];
  pptf_pkg::item_t                  rd_item_r;
  logic [pptf_pkg::FIFO_PW-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [pptf_pkg::FIFO_CW-1:0]     cnt_r, cnt_nxt;
  logic                             push, pop;

  assign wr_ready = cnt_r != pptf_pkg::FIFO_CW'(pptf_pkg::FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_item  = rd_item_r;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + pptf_pkg::FIFO_CW'(push) - pptf_pkg::FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the entry; prefetch the next head, passing through an item written to it
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
    if (push && (wr_ptr_r == rd_ptr_nxt)) begin
      rd_item_r <= wr_item;
    end else begin
      rd_item_r <= mem[rd_ptr_nxt];
    end
  end

  assign stat = '{count: cnt_r, push: push, pop: pop};

endmodule

@@ src/pptf_back.sv @@
module pptf_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  output logic                item_ready,
  input  pptf_pkg::item_t     item,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [143:0]        out_data
);

  localparam int N  = pptf_pkg::CORDIC_STAGES;
  localparam int CW = pptf_pkg::CW;
  localparam int AW = pptf_pkg::AW;
  localparam int PW = pptf_pkg::PW;

  logic                 en;
  logic [N+3:0]         vld_r;
  pptf_pkg::item_t      pay_r  [N+3];
  logic signed [CW-1:0] x_r    [N+1];
  logic signed [CW-1:0] y_r    [N+1];
  logic signed [AW-1:0] ang_r  [N+1];
  logic signed [CW-1:0] c, s;
  logic signed [PW-1:0] pac_r, pbs_r, pas_r, pbc_r;
  logic signed [PW:0]   sx_r, sy_r;
  logic signed [PW-29:0] rx, ry;
  logic signed [PW-28:0] tx, ty;
  logic signed [31:0]   ox_r, oy_r;
  pptf_pkg::item_t      fin_r;

  // Whole pipeline advances unless the output item is stalled
  assign en         = !vld_r[N+3] || out_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N+2:0], item_valid};
    end
  end

  // Load CORDIC start vector
  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= pptf_pkg::GAIN_Q30;
      y_r[0]   <= '0;
      ang_r[0] <= item.ang;
      pay_r[0] <= item;
    end
  end

  // CORDIC rotation stages
  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        pay_r[i+1] <= pay_r[i];
        if (ang_r[i] >= 0) begin
          x_r[i+1]   <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1]   <= y_r[i] + (x_r[i] >>> i);
          ang_r[i+1] <= ang_r[i] - pptf_pkg::atan_entry(i);
        end else begin
          x_r[i+1]   <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1]   <= y_r[i] - (x_r[i] >>> i);
          ang_r[i+1] <= ang_r[i] + pptf_pkg::atan_entry(i);
        end
      end
    end
  end

  // Undo half-turn fold
  assign c = pay_r[N].flip ? -x_r[N] : x_r[N];
  assign s = pay_r[N].flip ? -y_r[N] : y_r[N];

  // Products, sums, then round, offset and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      pac_r      <= PW'(pay_r[N].a) * PW'(c);
      pbs_r      <= PW'(pay_r[N].b) * PW'(s);
      pas_r      <= PW'(pay_r[N].a) * PW'(s);
      pbc_r      <= PW'(pay_r[N].b) * PW'(c);
      pay_r[N+1] <= pay_r[N];
      sx_r       <= (PW+1)'(pac_r) - (PW+1)'(pbs_r);
      sy_r       <= (PW+1)'(pas_r) + (PW+1)'(pbc_r);
      pay_r[N+2] <= pay_r[N+1];
      ox_r       <= (tx > 2147483647) ? 32'sh7fffffff :
                    (tx < -64'sd2147483648) ? 32'sh80000000 : 32'(tx);
      oy_r       <= (ty > 2147483647) ? 32'sh7fffffff :
                    (ty < -64'sd2147483648) ? 32'sh80000000 : 32'(ty);
      fin_r      <= pay_r[N+2];
    end
  end

  assign rx = (PW-28)'((sx_r + (PW+1)'(1 << 29)) >>> 30);
  assign ry = (PW-28)'((sy_r + (PW+1)'(1 << 29)) >>> 30);
  assign tx = (PW-27)'(rx) + (PW-27)'(pay_r[N+2].off_x);
  assign ty = (PW-27)'(ry) + (PW-27)'(pay_r[N+2].off_y);

  assign out_valid = vld_r[N+3];
  assign out_data  = {fin_r.heading, fin_r.pitch, fin_r.roll, fin_r.z, oy_r, ox_r};

endmodule

@@ src/planar_pose_frame_transform_unit.sv @@
// Channel | Ports           | tdata (low bit up)                         | tuser
// in      | in_t*           | pose x,y,z,roll,pitch,heading,ref x,y,head | req_type
// out     | out_t*          | out x,y,z,roll,pitch,heading               | none
//
// One pose per cycle sustained while the output is not stalled; items pass through the
// front register, the queue and the CORDIC/multiply/round pipeline.
// A 4-entry queue sits between classify front and CORDIC back; the back
// pipeline holds as a whole while the output item is stalled.
// Synchronous active-low reset clears all valid state; no clearing pass.
`include "planar_pose_frame_transform_unit_defines.svh"

module planar_pose_frame_transform_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pose_x, pose_y, pose_z, pose_roll, pose_pitch, pose_heading, ref_x, ref_y,
  // ref_heading
  input  logic [223:0] in_tdata,
  // req_type
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, out_roll, out_pitch, out_heading
  output logic [143:0] out_tdata
);

  logic                 f_valid, f_ready, q_valid, q_ready;
  pptf_pkg::item_t      f_item, q_item;
  pptf_pkg::fifo_stat_t q_stat;

  pptf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .req_type   (in_tuser),
    .in_data    (in_tdata),
    .item_valid (f_valid),
    .item_ready (f_ready),
    .item       (f_item)
  );

  pptf_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item),
    .stat     (q_stat)
  );

  pptf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item_ready (q_ready),
    .item       (q_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

  `PPTF_ASSERT(a_fifo_bound, q_stat.count <= pptf_pkg::FIFO_CW'(pptf_pkg::FIFO_DEPTH))
  `PPTF_ASSERT(a_pop_nonempty, q_stat.pop |-> q_stat.count != '0)
  `PPTF_ASSERT(a_full_blocks, q_stat.count == pptf_pkg::FIFO_CW'(pptf_pkg::FIFO_DEPTH) |-> !q_stat.push)
  `PPTF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid)

endmodule

@@ tb/planar_pose_frame_transform_unit_tb.sv @@
`timescale 1ns / 100ps

module planar_pose_frame_transform_unit_tb;

  localparam int NUM_RANDOM = 1100;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] roll;
    logic [15:0] pitch;
    logic [15:0] heading;
  } pose_out_t;

  // Cosine and sine in Q1.30 of a 16-bit binary angle
  function automatic void sin_cos_q30(input logic [15:0] ang16,
                                      output longint c, output longint s);
    longint a, x, y, xn, half, quarter, at;
    bit flip;
    longint unsigned t;
    int sh;
    a = longint'($signed(ang16));
    half = longint'(1) << (pptf_pkg::ANGLE_BITS - 1);
    quarter = longint'(1) << (pptf_pkg::ANGLE_BITS - 2);
    sh = 32 - pptf_pkg::ANGLE_BITS;
    if (pptf_pkg::ANGLE_BITS >= 16) a = a <<< (pptf_pkg::ANGLE_BITS - 16);
    else a = a >>> (16 - pptf_pkg::ANGLE_BITS);
    flip = 0;
    if (a > quarter || a < -quarter) begin
      flip = 1;
      a = (a < 0) ? a + half : a - half;
    end
    x = 652032874;
    y = 0;
    for (int i = 0; i < pptf_pkg::CORDIC_STAGES; i++) begin
      t = pptf_pkg::ATAN_TURN32[i % 32];
      if (sh > 0) t = (t + (longint'(1) << (sh - 1))) >> sh;
      at = longint'(t);
      if (a >= 0) begin
        xn = x - (y >>> (i % 32));
        y = y + (x >>> (i % 32));
        a = a - at;
      end else begin
        xn = x + (y >>> (i % 32));
        y = y - (x >>> (i % 32));
        a = a + at;
      end
      x = xn;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint round_q30(input longint v);
    return (v + (longint'(1) << 29)) >>> 30;
  endfunction

  // Work out the transformed pose of one request
  function automatic pose_out_t transform_pose(input logic [223:0] d, input logic to_robot);
    pose_out_t r;
    longint px, py, rx, ry, c, s, a, b, ox, oy;
    logic [15:0] ph, rh;
    px = longint'($signed(d[31:0]));
    py = longint'($signed(d[63:32]));
    ph = d[143:128];
    rx = longint'($signed(d[175:144]));
    ry = longint'($signed(d[207:176]));
    rh = d[223:208];
    if (to_robot == pptf_pkg::REQ_TO_FIELD) begin
      sin_cos_q30(rh, c, s);
      ox = round_q30(px * c - py * s) + rx;
      oy = round_q30(px * s + py * c) + ry;
      r.heading = ph + rh;
    end else begin
      sin_cos_q30(16'(-rh), c, s);
      a = px - rx;
      b = py - ry;
      ox = round_q30(a * c - b * s);
      oy = round_q30(a * s + b * c);
      r.heading = ph - rh;
    end
    r.x = clamp32(ox);
    r.y = clamp32(oy);
    r.z = d[95:64];
    r.roll = d[111:96];
    r.pitch = d[127:112];
    return r;
  endfunction

  int error_count = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
    error_count++;
  endtask

  class pose_scoreboard;
    pose_out_t pending_poses[$];

    function void note_request(input logic [223:0] d, input logic to_robot);
      pending_poses.push_back(transform_pose(d, to_robot));
    endfunction

    task check_pose(input logic [143:0] d);
      pose_out_t e;
      if (pending_poses.size() == 0) begin
        report_mismatch("unexpected item", d[31:0], 0);
        return;
      end
      e = pending_poses.pop_front();
      if (d[31:0] !== e.x) report_mismatch("x", d[31:0], e.x);
      if (d[63:32] !== e.y) report_mismatch("y", d[63:32], e.y);
      if (d[95:64] !== e.z) report_mismatch("z", d[95:64], e.z);
      if (d[111:96] !== e.roll) report_mismatch("roll", d[111:96], e.roll);
      if (d[127:112] !== e.pitch) report_mismatch("pitch", d[127:112], e.pitch);
      if (d[143:128] !== e.heading) report_mismatch("heading", d[143:128], e.heading);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [223:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [143:0] out_tdata;

  pose_scoreboard sb = new();
  int idle_cycles = 0;
  bit hold_off = 0;
  int out_mode = 0;

  always #1 clk = ~clk;

  planar_pose_frame_transform_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_pose(input logic [223:0] d, input logic to_robot, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    in_tuser <= to_robot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(d, to_robot);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return {$urandom_range(0, 1) ? 2'b01 : 2'b10, 30'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
    endcase
  endfunction

  function automatic logic [15:0] rand_ang();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h4000 + 16'($urandom_range(0, 2)) - 16'd1;
      2: return 16'hc000 + 16'($urandom_range(0, 2)) - 16'd1;
      3: return 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [223:0] make_pose(input logic [31:0] px, input logic [31:0] py,
                                            input logic [15:0] ph, input logic [31:0] rx,
                                            input logic [31:0] ry, input logic [15:0] rh);
    return {rh, ry, rx, ph, 16'($urandom()), 16'($urandom()), 32'($urandom()), py, px};
  endfunction

  // Receiver: random stalls, and one long hold-off
  always @(negedge clk) begin
    if (hold_off) out_tready <= 0;
    else if (out_mode == 0) out_tready <= 1;
    else out_tready <= ($urandom_range(0, 9) < 6);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_pose(out_tdata);
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("timeout waiting for results");
      $display("planar_pose_frame_transform_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [31:0] pv [6];
    logic [15:0] av [5];
    pv = '{32'h0, 32'h00010000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h40000000};
    av = '{16'h0000, 16'h4000, 16'hc000, 16'h8000, 16'h7fff};
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: field extremes, both operations, heading of minus pi, overflow
    for (int i = 0; i < 5; i++) begin
      send_pose(make_pose(pv[i], pv[(i + 2) % 6], av[i], pv[(i + 3) % 6], pv[(i + 1) % 6],
                          av[(i + 3) % 5]), pptf_pkg::REQ_TO_FIELD, 0);
      send_pose(make_pose(pv[(i + 1) % 6], pv[i], av[(i + 1) % 5], pv[(i + 4) % 6], pv[i],
                          av[i]), pptf_pkg::REQ_TO_ROBOT, 0);
    end
    send_pose({16'h8000, 32'h80000000, 32'h80000000, 16'h8000, 16'hffff, 16'hffff,
               32'hffffffff, 32'h7fffffff, 32'h7fffffff}, pptf_pkg::REQ_TO_ROBOT, 0);
    send_pose({16'h7fff, 32'h7fffffff, 32'h7fffffff, 16'h7fff, 16'h0, 16'h0,
               32'h0, 32'h7fffffff, 32'h7fffffff}, pptf_pkg::REQ_TO_FIELD, 0);
    send_pose({16'h2000, 32'h80000000, 32'h7fffffff, 16'h8000, 16'h8000, 16'h7fff,
               32'h80000000, 32'h80000000, 32'h7fffffff}, pptf_pkg::REQ_TO_FIELD, 0);

    // Long receiver hold-off while items keep coming
    fork
      begin
        hold_off = 1;
        repeat (60) @(negedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 40; i++)
        send_pose(make_pose(rand_pos(), rand_pos(), rand_ang(), rand_pos(), rand_pos(),
                            rand_ang()), logic'($urandom_range(0, 1)), 0);
    join

    // Random phases: back-to-back, then with gaps and stalls
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 200 == 0) out_mode = (i / 200) % 2;
      send_pose(make_pose(rand_pos(), rand_pos(), rand_ang(), rand_pos(), rand_pos(),
                          rand_ang()), logic'($urandom_range(0, 1)), (i / 100) % 2 == 1);
    end
    in_tvalid <= 0;
    out_mode = 0;

    while (sb.pending_poses.size() != 0) @(negedge clk);
    repeat (pptf_pkg::CORDIC_STAGES + 10) @(negedge clk);
    if (error_count == 0)
      $display("planar_pose_frame_transform_unit_tb: done, clean");
    else
      $display("planar_pose_frame_transform_unit_tb: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/pptf_pkg.sv
src/pptf_front.sv
src/pptf_fifo.sv
src/pptf_back.sv
src/planar_pose_frame_transform_unit.sv
tb/planar_pose_frame_transform_unit_tb.sv
